// ===== hw/rtl/rbf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared widths, reset values, the window job record and the state codes of
// the row box filter.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int PIX_W             = 8;
    localparam int RAD_W             = 4;
    localparam int SUM_W             = 13;
    localparam int CNT_W             = 5;
    localparam int RECIP_W           = 16;
    localparam int RECIP_SHIFT       = 15;
    localparam int MAX_RADIUS_DEF    = 15;
    localparam int MAX_ROW_WIDTH_DEF = 4096;
    localparam int RADIUS_RESET      = 2;
    localparam int QUEUE_DEPTH       = 4;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             exact;
        logic [CNT_W-1:0] count;
        logic             row_end;
        logic             run_end;
    } t_job;

    typedef enum logic [1:0] {
        S_IN,
        S_UPD,
        S_FRD,
        S_FPUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_FIN
    } t_back_state;

    // floor(2^15 / (2r+1))
    function automatic logic [RECIP_W-1:0] recip_of(input logic [RAD_W-1:0] radius);
        logic [RECIP_W-1:0] f;
        case (radius)
            4'd0:    f = 16'd32768;
            4'd1:    f = 16'd10922;
            4'd2:    f = 16'd6553;
            4'd3:    f = 16'd4681;
            4'd4:    f = 16'd3640;
            4'd5:    f = 16'd2978;
            4'd6:    f = 16'd2520;
            4'd7:    f = 16'd2184;
            4'd8:    f = 16'd1927;
            4'd9:    f = 16'd1724;
            4'd10:   f = 16'd1560;
            4'd11:   f = 16'd1424;
            4'd12:   f = 16'd1310;
            4'd13:   f = 16'd1213;
            4'd14:   f = 16'd1129;
            4'd15:   f = 16'd1057;
            default: f = 16'd6553;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/row_box_filter_edge_normalized.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// row_box_filter_edge_normalized
// One-dimensional box filter over an image row, with true-count means where
// the window is clipped at the row edges.
//
// Pixels enter on the i_valid/o_ready channel, i_row_last on the final pixel
// of a row. Means leave on the o_valid/i_ready channel with o_row_end on the
// last mean of a row and o_run_end on the last mean caused by an input pixel.
// The radius is written through i_cfg_we/i_cfg_data only while the block is
// idle, a rule for the user that the block itself does not enforce; a write
// restarts the row. Reset sets radius 2 and an empty row. In the front a
// pixel passes a ring read, then a sum update. A full window mean takes one
// multiply in the back; an edge mean goes to the divider instead, 4 quotient
// bits a cycle. The last pixel of a row keeps intake closed while the flush
// reads the pixel ring once per result.
// A stalled receiver holds the output register; up to 4 jobs then collect in
// the queue before the front stops taking pixels.
// ----------------------------------------------------------------------------
module row_box_filter_edge_normalized #(
    parameter int MAX_RADIUS    = rbf_pkg::MAX_RADIUS_DEF,
    parameter int MAX_ROW_WIDTH = rbf_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rbf_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_row_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rbf_pkg::PIX_W-1:0]   o_mean_value,
    output logic                        o_row_end,
    output logic                        o_run_end,
    input  logic                        i_cfg_we,
    input  logic [rbf_pkg::RAD_W-1:0]   i_cfg_data
);
    import rbf_pkg::*;

    logic               fq_valid;
    logic               fq_ready;
    t_job               fq_job;
    logic               qb_valid;
    logic               qb_ready;
    t_job               qb_job;
    logic [RECIP_W-1:0] recip;

    rbf_front #(
        .MAX_RADIUS    (MAX_RADIUS),
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .i_row_last  (i_row_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job),
        .o_recip     (recip)
    );

    rbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_job),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_job)
    );

    rbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (qb_valid),
        .o_job_ready  (qb_ready),
        .i_job        (qb_job),
        .i_recip      (recip),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mean_value (o_mean_value),
        .o_row_end    (o_row_end),
        .o_run_end    (o_run_end)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/rbf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_front
// Takes pixels in, keeps the pixel ring, running sum and column count, and
// turns each pixel into window jobs: one per interior pixel, a flush of jobs
// on the last pixel of a row.
// ----------------------------------------------------------------------------
module rbf_front #(
    parameter int MAX_RADIUS    = rbf_pkg::MAX_RADIUS_DEF,
    parameter int MAX_ROW_WIDTH = rbf_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rbf_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_row_last,
    input  logic                          i_cfg_we,
    input  logic [rbf_pkg::RAD_W-1:0]     i_cfg_data,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output rbf_pkg::t_job                 o_job,
    output logic [rbf_pkg::RECIP_W-1:0]   o_recip
);
    import rbf_pkg::*;

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_ROW_WIDTH);
    localparam logic [AW:0]      DEPTH_A  = (AW+1)'(DEPTH);
    localparam logic [AW-1:0]    HEAD_TOP = AW'(DEPTH - 1);
    localparam logic [PW-1:0]    SEEN_SAT = PW'(MAX_ROW_WIDTH - 1);
    localparam logic [RAD_W-1:0] RAD_RST  = (MAX_RADIUS < RADIUS_RESET) ?
                                            RAD_W'(MAX_RADIUS) : RAD_W'(RADIUS_RESET);

    t_front_state       r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [PW-1:0]      r_seen, n_seen;
    logic [RAD_W-1:0]   r_radius, n_radius;
    logic [RECIP_W-1:0] r_recip, n_recip;
    logic [RAD_W-1:0]   r_t, n_t;
    logic [PIX_W-1:0]   r_pix;
    logic               r_last;
    logic [PIX_W-1:0]   r_rd;
    logic [PIX_W-1:0]   mem [DEPTH];

    logic               accept;
    logic               mem_re;
    logic [AW:0]        rd_sum;
    logic [AW-1:0]      rd_addr;
    logic [RAD_W:0]     span;
    logic [RAD_W:0]     twice_r;
    logic [PW:0]        seen_x;
    logic [PW:0]        span_x;
    logic [PW:0]        cnt_a;
    logic [PW:0]        cnt_b;
    logic               t_nz;
    logic               sub_en;
    logic               last_job;
    logic [SUM_W-1:0]   sum_base;
    logic [SUM_W-1:0]   sum_job;
    logic [RAD_W-1:0]   cfg_rad;

    assign span    = {r_radius, 1'b1};
    assign twice_r = {r_radius, 1'b0};
    assign o_ready = (r_state == S_IN);
    assign accept  = i_valid && o_ready;
    assign mem_re  = accept || (r_state == S_FRD);
    assign o_recip = r_recip;

    assign rd_sum  = (AW+1)'(r_head) + DEPTH_A - (AW+1)'(span)
                   + ((r_state == S_FRD) ? (AW+1)'(r_t - RAD_W'(1)) : (AW+1)'(0));
    assign rd_addr = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : AW'(rd_sum);

    assign seen_x  = {1'b0, r_seen};
    assign span_x  = (PW+1)'(span);
    assign t_nz    = (r_t != '0);
    assign sub_en  = (r_state == S_UPD) ? (seen_x >= span_x)
                   : (t_nz && ((seen_x + (PW+1)'(r_t)) >= span_x));
    assign sum_base = r_sum - (sub_en ? SUM_W'(r_rd) : SUM_W'(0));
    assign sum_job  = sum_base + ((r_state == S_UPD) ? SUM_W'(r_pix) : SUM_W'(0));

    assign cnt_a    = (PW+1)'(span - (RAD_W+1)'(r_t));
    assign cnt_b    = seen_x + (PW+1)'(1);
    assign last_job = (seen_x >= (PW+1)'(r_radius)) ? (r_t == r_radius)
                                                    : ((PW+1)'(r_t) == seen_x);

    assign o_job.sum     = sum_job;
    assign o_job.exact   = t_nz || (seen_x <= (PW+1)'(twice_r));
    assign o_job.count   = CNT_W'((cnt_a < cnt_b) ? cnt_a : cnt_b);
    assign o_job.row_end = (r_state == S_FPUSH) && last_job;
    assign o_job.run_end = (r_state != S_FPUSH) || last_job;
    assign o_job_valid   = ((r_state == S_UPD) && !r_last
                            && (seen_x >= (PW+1)'(r_radius)))
                         || (r_state == S_FPUSH);

    assign cfg_rad = (32'(i_cfg_data) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : i_cfg_data;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_sum    = r_sum;
        n_seen   = r_seen;
        n_radius = r_radius;
        n_recip  = r_recip;
        n_t      = r_t;
        case (r_state)
            S_IN: begin
                if (accept) begin
                    n_head  = (r_head == HEAD_TOP) ? AW'(0) : r_head + AW'(1);
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_last) begin
                    n_sum   = sum_job;
                    n_t     = '0;
                    n_state = S_FPUSH;
                end else if (!o_job_valid || i_job_ready) begin
                    n_sum   = sum_job;
                    n_seen  = (r_seen == SEEN_SAT) ? r_seen : r_seen + PW'(1);
                    n_state = S_IN;
                end
            end
            S_FRD: begin
                n_state = S_FPUSH;
            end
            S_FPUSH: begin
                if (i_job_ready) begin
                    if (last_job) begin
                        n_sum   = '0;
                        n_seen  = '0;
                        n_t     = '0;
                        n_state = S_IN;
                    end else begin
                        n_sum   = sum_job;
                        n_t     = r_t + RAD_W'(1);
                        n_state = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
        if (i_cfg_we) begin
            n_radius = cfg_rad;
            n_recip  = recip_of(cfg_rad);
            n_sum    = '0;
            n_seen   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IN;
            r_head   <= '0;
            r_sum    <= '0;
            r_seen   <= '0;
            r_radius <= RAD_RST;
            r_recip  <= recip_of(RAD_RST);
            r_t      <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_sum    <= n_sum;
            r_seen   <= n_seen;
            r_radius <= n_radius;
            r_recip  <= n_recip;
            r_t      <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_pixel;
            r_last <= i_row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_head] <= i_pixel;
        end
        if (mem_re) begin
            r_rd <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rbf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_queue
// Short job queue between the front and the back of the filter.
// ----------------------------------------------------------------------------
module rbf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rbf_pkg::t_job i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rbf_pkg::t_job o_data
);
    import rbf_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam logic [QAW:0] FULL = (QAW+1)'(QUEUE_DEPTH);

    t_job           r_slot [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr, r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           push;
    logic           pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rbf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_back
// Carries out window jobs: reciprocal multiply for full windows, iterative
// division by the true count for edge windows, and holds the result.
// ----------------------------------------------------------------------------
module rbf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    output logic                         o_job_ready,
    input  rbf_pkg::t_job                i_job,
    input  logic [rbf_pkg::RECIP_W-1:0]  i_recip,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rbf_pkg::PIX_W-1:0]    o_mean_value,
    output logic                         o_row_end,
    output logic                         o_run_end
);
    import rbf_pkg::*;

    localparam int DIV_STEPS = 4;
    localparam int DIV_W     = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int ITERS     = DIV_W / DIV_STEPS;
    localparam int IW        = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    t_back_state        r_state, n_state;
    t_job               r_job;
    logic [DIV_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [IW-1:0]      r_iter, n_iter;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_mean;
    logic               r_row_end;
    logic               r_run_end;

    logic [PROD_W-1:0]  prod;
    logic               out_free;
    logic               take;
    logic               load;
    logic [PIX_W-1:0]   load_mean;
    logic [DIV_W-1:0]   step_quo;
    logic [CNT_W-1:0]   step_rem;

    assign o_job_ready  = (r_state == B_IDLE);
    assign take         = i_job_valid && o_job_ready;
    assign out_free     = !r_out_valid || i_ready;
    assign prod         = PROD_W'(r_job.sum) * PROD_W'(i_recip);
    assign o_valid      = r_out_valid;
    assign o_mean_value = r_mean;
    assign o_row_end    = r_row_end;
    assign o_run_end    = r_run_end;

    always_comb begin
        logic [CNT_W:0]   rem_x;
        logic [CNT_W-1:0] rem_v;
        logic [DIV_W-1:0] quo_v;
        rem_v = r_rem;
        quo_v = r_quo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            rem_x = {rem_v, quo_v[DIV_W-1]};
            quo_v = {quo_v[DIV_W-2:0], 1'b0};
            if (rem_x >= {1'b0, r_job.count}) begin
                rem_v    = CNT_W'(rem_x - {1'b0, r_job.count});
                quo_v[0] = 1'b1;
            end else begin
                rem_v = rem_x[CNT_W-1:0];
            end
        end
        step_rem = rem_v;
        step_quo = quo_v;
    end

    always_comb begin
        n_state   = r_state;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_iter    = r_iter;
        load      = 1'b0;
        load_mean = prod[RECIP_SHIFT +: PIX_W];
        case (r_state)
            B_IDLE: begin
                if (take) begin
                    n_quo  = DIV_W'(i_job.sum);
                    n_rem  = '0;
                    n_iter = '0;
                    n_state = i_job.exact ? B_DIV : B_MUL;
                end
            end
            B_MUL: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_DIV: begin
                n_quo  = step_quo;
                n_rem  = step_rem;
                n_iter = r_iter + IW'(1);
                if (r_iter == IW'(ITERS - 1)) begin
                    n_state = B_FIN;
                end
            end
            B_FIN: begin
                load_mean = r_quo[PIX_W-1:0];
                if (out_free) begin
                    load    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_iter <= n_iter;
        if (load) begin
            r_mean    <= load_mean;
            r_row_end <= r_job.row_end;
            r_run_end <= r_job.run_end;
        end
    end

endmodule
`default_nettype wire

// ===== verif/row_box_filter_edge_normalized_tb.sv =====
// ----------------------------------------------------------------------------
// row_box_filter_edge_normalized_tb
// Self-checking bench for the row box filter. A driver offers pixels from a
// queue in bursts with random gaps; the receiver stalls on its own changing
// pattern, with one long hold-off that fills the block. A cycle-free model of
// the filter predicts every mean with its row-end and run-end flags, and the
// monitor checks each transfer in order. Directed rows cover single-pixel,
// short, exact-span and extreme-valued rows; random phases cycle the radius
// through its extremes and cut one row short with a radius write.
// ----------------------------------------------------------------------------
module row_box_filter_edge_normalized_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_LEN      = 2 * rbf_pkg::MAX_RADIUS_DEF + 1;
    localparam int ROW_SAT       = rbf_pkg::MAX_ROW_WIDTH_DEF - 1;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 16;

    typedef struct packed {
        logic [rbf_pkg::PIX_W-1:0] pixel;
        logic                      row_last;
    } t_pix;

    typedef struct packed {
        logic [rbf_pkg::PIX_W-1:0] mean;
        logic                      row_end;
        logic                      run_end;
    } t_mean;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_valid    = 1'b0;
    logic                      o_ready;
    logic [rbf_pkg::PIX_W-1:0] i_pixel    = '0;
    logic                      i_row_last = 1'b0;
    logic                      o_valid;
    logic                      i_ready    = 1'b0;
    logic [rbf_pkg::PIX_W-1:0] o_mean_value;
    logic                      o_row_end;
    logic                      o_run_end;
    logic                      i_cfg_we   = 1'b0;
    logic [rbf_pkg::RAD_W-1:0] i_cfg_data = '0;

    t_pix  pix_q[$];
    t_mean mean_q[$];

    logic [rbf_pkg::PIX_W-1:0] ring [RING_LEN];
    int ring_head = 0;
    int win_sum   = 0;
    int row_pos   = 0;
    int win_rad   = rbf_pkg::RADIUS_RESET;
    int recip     = 32768 / (2 * rbf_pkg::RADIUS_RESET + 1);

    bit pix_taken    = 1'b0;
    int mismatch_cnt = 0;
    int stall_cycles = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int burst_left   = 8;
    int gap_left     = 0;
    int rcv_mode     = 0;
    int rcv_tick     = 0;
    logic [3:0] rcv_phase = '0;

    row_box_filter_edge_normalized dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_row_last   (i_row_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mean_value (o_mean_value),
        .o_row_end    (o_row_end),
        .o_run_end    (o_run_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [rbf_pkg::PIX_W-1:0] win_mean(int j, int p, bit known_end);
        int  lo;
        int  hi;
        bit  exact;
        lo = j - win_rad;
        hi = j + win_rad;
        if (lo < 0) lo = 0;
        if (known_end && hi > p) hi = p;
        exact = (j <= win_rad) || (known_end && j + win_rad > p);
        if (exact) return 8'(win_sum / (hi - lo + 1));
        return 8'((win_sum * recip) >>> rbf_pkg::RECIP_SHIFT);
    endfunction

    function automatic void filt_step(logic [rbf_pkg::PIX_W-1:0] pix, logic last);
        int    p;
        int    span;
        int    j0;
        int    j;
        t_mean m;
        p    = row_pos;
        span = 2 * win_rad + 1;
        if (p >= span) win_sum -= ring[(ring_head + RING_LEN - span) % RING_LEN];
        ring[ring_head] = pix;
        ring_head = (ring_head + 1) % RING_LEN;
        win_sum = (win_sum + pix) & 'h1FFF;
        if (!last) begin
            if (p >= win_rad) begin
                m = '{mean: win_mean(p - win_rad, p, 1'b0), row_end: 1'b0, run_end: 1'b1};
                mean_q.push_back(m);
            end
            if (row_pos < ROW_SAT) row_pos++;
        end else begin
            j0 = (p >= win_rad) ? p - win_rad : 0;
            for (j = j0; j <= p; j++) begin
                if (j > j0 && j - win_rad - 1 >= 0)
                    win_sum -= ring[(ring_head + 2 * RING_LEN - 1 - (p - (j - win_rad - 1)))
                                    % RING_LEN];
                m = '{mean: win_mean(j, p, 1'b1), row_end: (j == p), run_end: (j == p)};
                mean_q.push_back(m);
            end
            win_sum = 0;
            row_pos = 0;
        end
    endfunction

    function automatic logic [rbf_pkg::PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_len(int r);
        case ($urandom_range(0, 7))
            0:       return $urandom_range(1, r + 1);
            1:       return 2 * r + 1;
            2:       return 2 * r + 2;
            default: return $urandom_range(1, 2 * r + 12);
        endcase
    endfunction

    task automatic push_px(input logic [rbf_pkg::PIX_W-1:0] pix, input logic last);
        pix_q.push_back('{pixel: pix, row_last: last});
    endtask

    task automatic push_row(input int len, input bit close);
        int i;
        for (i = 0; i < len; i++) push_px(rand_pix(), close && (i == len - 1));
    endtask

    task automatic settle_all();
        while (pix_q.size() != 0 || i_valid) @(posedge i_clk);
        while (mean_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // restart the row in the model along with the block
    task automatic set_radius(input int r);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r[rbf_pkg::RAD_W-1:0];
        win_rad = r;
        recip   = 32768 / (2 * r + 1);
        win_sum = 0;
        row_pos = 0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin : driver
        logic nxt_valid;
        t_pix nxt;
        nxt_valid = i_valid;
        nxt       = '{pixel: i_pixel, row_last: i_row_last};
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_valid || pix_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pix_q.size() != 0) begin
                nxt       = pix_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        i_valid    <= nxt_valid;
        i_pixel    <= nxt.pixel;
        i_row_last <= nxt.row_last;
    end

    always @(negedge i_clk) begin : receiver
        logic rdy;
        rcv_phase = rcv_phase + 1'b1;
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            if (rcv_tick == 0) begin
                rcv_mode = $urandom_range(0, 3);
                rcv_tick = $urandom_range(16, 96);
            end else begin
                rcv_tick--;
            end
            case (rcv_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = (rcv_phase[2:1] != 2'b11);
            endcase
        end
        i_ready <= rdy;
    end

    always @(posedge i_clk) begin : monitor
        t_mean want;
        bit    moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            pix_taken = 1'b0;
        end else begin
            if ((o_valid && i_ready) === 1'b1) begin
                moved = 1'b1;
                if (mean_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected transfer: mean %0d row_end %0b run_end %0b",
                                 o_mean_value, o_row_end, o_run_end);
                    mismatch_cnt++;
                end else begin
                    want = mean_q.pop_front();
                    if (o_mean_value !== want.mean || o_row_end !== want.row_end ||
                        o_run_end !== want.run_end) begin
                        if (mismatch_cnt < 10)
                            $display("mismatch: mean %0d/%0d row_end %0b/%0b run_end %0b/%0b",
                                     want.mean, o_mean_value, want.row_end, o_row_end,
                                     want.run_end, o_run_end);
                        mismatch_cnt++;
                    end
                end
            end
            pix_taken = ((i_valid && o_ready) === 1'b1);
            if (pix_taken) begin
                moved = 1'b1;
                filt_step(i_pixel, i_row_last);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int n_added;
        int len;
        int rad;
        int k;
        int phase_rad [8];
        phase_rad = '{0, 15, 1, 2, 7, 3, -1, -1};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default radius: lone pixel, short row, exact span, extremes
        push_px(8'd255, 1'b1);
        push_px(8'd0, 1'b0);
        push_px(8'd255, 1'b1);
        repeat (4) push_px(8'd255, 1'b0);
        push_px(8'd255, 1'b1);
        push_px(8'd0, 1'b0);
        push_px(8'd255, 1'b0);
        push_px(8'd0, 1'b0);
        push_px(8'd255, 1'b0);
        push_px(8'd170, 1'b0);
        push_px(8'd85, 1'b0);
        push_px(8'd0, 1'b0);
        push_px(8'd255, 1'b1);
        settle_all();
        set_radius(0);
        push_px(8'd255, 1'b0);
        push_px(8'd0, 1'b0);
        push_px(8'd255, 1'b1);
        settle_all();
        set_radius(rbf_pkg::MAX_RADIUS_DEF);
        push_px(8'd255, 1'b0);
        push_px(8'd255, 1'b0);
        push_px(8'd1, 1'b1);

        for (k = 0; k < 8; k++) begin
            settle_all();
            rad = (phase_rad[k] < 0) ? $urandom_range(0, rbf_pkg::MAX_RADIUS_DEF) : phase_rad[k];
            set_radius(rad);
            if (phase_rad[k] == 7) hold_asked++;
            n_added = 0;
            while (n_added < PHASE_ITEMS) begin
                len = pick_len(rad);
                push_row(len, 1'b1);
                n_added += len;
            end
            // leave a row open; the next radius write restarts it
            if (phase_rad[k] == 3) push_row($urandom_range(1, 8), 1'b0);
        end

        settle_all();

        if (mismatch_cnt == 0 && mean_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
